// ----- hdl/tfic_pkg.sv -----
// shared types, constants and table functions of the thermistor fan integral controller
// no dependencies; every other file of the block imports this package
package tfic_pkg;

  localparam int AdcBits = 12;
  localparam int Depth = 1 << AdcBits;
  localparam int unsigned AdcTop = Depth - 1;
  localparam int FracBits = 28;
  localparam logic [63:0] Ln2Q28 = 64'd186065279;
  localparam longint BetaScaled = 64'sd397700;
  localparam longint T0Scaled = 64'sd29815;
  localparam longint KelvinNum = 64'sd11857425500 <<< FracBits;
  localparam int ZeroCHund = 27300;

  localparam int TempW = 17;
  localparam int ErrW = 18;
  localparam int ProdW = 27;
  localparam int SumW = 28;
  localparam int LevelW = 15;
  localparam int PosW = 16;
  localparam int DigW = 14;

  localparam logic [7:0] TargetReset = 8'd38;
  localparam logic [7:0] GainReset = 8'd32;
  localparam logic [LevelW-1:0] LevelReset = 15'd1000;
  localparam logic [7:0] DutyReset = 8'd10;
  localparam logic [7:0] DutyKick = 8'd30;
  localparam logic [LevelW-1:0] LevelStop = 15'd1500;
  localparam int LevelMax = 25500;

  localparam int RecipTenK = 53688;
  localparam int TenK = 10000;
  localparam int RecipThou = 16778;
  localparam int RecipHund = 5243;
  localparam int RecipTen = 6554;

  localparam int FifoDepth = 4;
  localparam int MsgLen = 8;
  localparam int IdxW = $clog2(MsgLen);

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharDot = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharC = 8'h43;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdTarget = 1'b1
  } command_e;

  typedef logic signed [TempW-1:0] temp_t;

  typedef struct packed {
    command_e           command;
    logic [AdcBits-1:0] adc_code;
    logic [7:0]         target_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] tx_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    temp_t      temp;
    logic [7:0] target;
  } sample_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [3:0] tens;
    logic [3:0] units;
    logic [3:0] tenths;
    logic [3:0] hundredths;
  } report_t;

  // log2 in q28 by repeated squaring of the mantissa
  function automatic logic [63:0] log2_q28(input logic [31:0] n);
    logic [63:0] m;
    logic [63:0] res;
    logic [5:0]  k;
    k = '0;
    for (int b = 0; b < 32; b++) begin
      if (n[b]) begin
        k = 6'(b);
      end
    end
    m = ({32'd0, n} << FracBits) >> k;
    res = 64'(k) << FracBits;
    for (int i = FracBits - 1; i >= 0; i--) begin
      m = (m * m) >> FracBits;
      if (m >= (64'd2 << FracBits)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] ln_q28(input logic [31:0] n);
    return (log2_q28(n) * Ln2Q28) >> FracBits;
  endfunction

  // denominator of the beta curve for one adc code
  function automatic longint temp_denom(input logic [31:0] code);
    longint l;
    l = longint'(ln_q28(32'(AdcTop) - code)) - longint'(ln_q28(code));
    return (BetaScaled <<< FracBits) + T0Scaled * l;
  endfunction

endpackage

// ----- hdl/tfic_fifo.sv -----
// short sample queue between the front end and the control pipeline
// depends on tfic_pkg
module tfic_fifo #(
  parameter int DEPTH = tfic_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tfic_pkg::sample_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tfic_pkg::sample_t data_o
);
  import tfic_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  sample_t         mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/tfic_front.sv -----
// front end: takes input words, keeps the target and looks up the temperature rom
// depends on tfic_pkg; feeds tfic_fifo
module tfic_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tfic_pkg::in_item_t item_i,
  input  logic               fifo_full_i,
  output logic               fifo_push_o,
  output tfic_pkg::sample_t  fifo_data_o
);
  import tfic_pkg::*;

  temp_t      rom_table [Depth];
  logic       accept, sample_acc;
  logic       st_v_q;
  temp_t      temp_q;
  logic [7:0] snap_q;
  logic [7:0] target_q;

  // beta-curve table, evaluated at elaboration
  for (genvar c = 0; c < Depth; c++) begin : g_rom
    localparam longint DVal = temp_denom(32'(c));
    localparam bit Singular = (c == 0) || (c >= AdcTop) || (DVal <= 0);
    localparam longint DPos = Singular ? 64'sd1 : DVal;
    localparam longint Kelvin = (KelvinNum + DPos / 2) / DPos;
    localparam int Entry = Singular ? -ZeroCHund : int'(Kelvin) - ZeroCHund;
    assign rom_table[c] = TempW'(Entry);
  end

  assign fifo_push_o = st_v_q && !fifo_full_i;
  assign full_o      = st_v_q && fifo_full_i;
  assign accept      = push_i && !full_o;
  assign sample_acc  = accept && (item_i.command == CmdSample);
  assign fifo_data_o = '{temp: temp_q, target: snap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q   <= 1'b0;
      target_q <= TargetReset;
    end else begin
      if (sample_acc) begin
        st_v_q <= 1'b1;
      end else if (fifo_push_o) begin
        st_v_q <= 1'b0;
      end
      if (accept && (item_i.command == CmdTarget)) begin
        target_q <= item_i.target_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      temp_q <= rom_table[item_i.adc_code];
      snap_q <= target_q;
    end
  end

endmodule

// ----- hdl/tfic_ctrl.sv -----
// control pipeline: integral update, duty rule and decimal digits of the temperature
// depends on tfic_pkg; reads tfic_fifo and feeds tfic_report
module tfic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              fifo_empty_i,
  output logic              fifo_pop_o,
  input  tfic_pkg::sample_t fifo_data_i,
  output logic              rpt_valid_o,
  input  logic              rpt_ready_i,
  output tfic_pkg::report_t rpt_o
);
  import tfic_pkg::*;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic mv1, mv2, mv3, mv4;

  logic [7:0]        gain_q;
  logic [LevelW-1:0] level_q;
  logic [7:0]        duty_q;

  // stage 1
  logic [14:0]             tgt_hund;
  logic signed [ErrW-1:0]  err_d, err1_q;
  logic [PosW-1:0]         tpos_d, tpos1_q;
  // stage 2
  logic signed [ProdW-1:0] err_ext, gain_ext, prod2_q;
  logic [31:0]             qprod;
  logic [2:0]              q2_q;
  logic [PosW-1:0]         tpos2_q;
  // stage 3
  logic signed [ProdW-1:0] bias, prod_rnd, delta;
  logic signed [SumW-1:0]  sum;
  logic [LevelW-1:0]       level_d, lev3_q;
  logic [PosW-1:0]         qk, dfull;
  logic [DigW-1:0]         d3_q;
  // stage 4
  logic [27:0]             th_p;
  logic [25:0]             e_p, f_p;
  logic [26:0]             lev_p;
  logic [3:0]              th4_q;
  logic [6:0]              e4_q;
  logic [9:0]              f4_q;
  logic [DigW-1:0]         d4_q;
  logic [7:0]              levdiv4_q;
  logic                    levpos4_q, levlow4_q;
  // report
  logic [7:0]              duty_d;
  logic [6:0]              units_w;
  logic [9:0]              tenths_w;
  logic [DigW-1:0]         hund_w;

  assign mv4 = s4_v_q && rpt_ready_i;
  assign mv3 = s3_v_q && (!s4_v_q || mv4);
  assign mv2 = s2_v_q && (!s3_v_q || mv3);
  assign mv1 = s1_v_q && (!s2_v_q || mv2);
  assign fifo_pop_o  = !fifo_empty_i && (!s1_v_q || mv1);
  assign rpt_valid_o = s4_v_q;

  // error against target, clipped temperature for the report
  assign tgt_hund = 15'(fifo_data_i.target) * 15'(100);
  assign err_d    = ErrW'(fifo_data_i.temp) - ErrW'($signed({1'b0, tgt_hund}));
  assign tpos_d   = fifo_data_i.temp[TempW-1] ? '0 : fifo_data_i.temp[PosW-1:0];

  // gain product, ten-thousands digit
  assign err_ext  = ProdW'(err1_q);
  assign gain_ext = ProdW'($signed({1'b0, gain_q}));
  assign qprod    = 32'(tpos1_q) * 32'(RecipTenK);

  // sixteenths toward zero, level clamp, remainder below ten thousand
  assign bias     = prod2_q[ProdW-1] ? ProdW'(15) : ProdW'(0);
  assign prod_rnd = prod2_q + bias;
  assign delta    = prod_rnd >>> 4;
  assign sum      = SumW'(delta) + SumW'($signed({1'b0, level_q}));
  always_comb begin
    if (sum[SumW-1]) begin
      level_d = '0;
    end else if (sum > SumW'(LevelMax)) begin
      level_d = LevelW'(LevelMax);
    end else begin
      level_d = sum[LevelW-1:0];
    end
  end
  assign qk    = PosW'(q2_q) * PosW'(TenK);
  assign dfull = tpos2_q - qk;

  // digit quotients and level over one hundred
  assign th_p  = 28'(d3_q) * 28'(RecipThou);
  assign e_p   = 26'(d3_q) * 26'(RecipHund);
  assign f_p   = 26'(d3_q) * 26'(RecipTen);
  assign lev_p = 27'(lev3_q) * 27'(RecipHund);

  // duty rule and final digits
  always_comb begin
    if (duty_q == '0) begin
      duty_d = levpos4_q ? DutyKick : '0;
    end else if (levlow4_q) begin
      duty_d = '0;
    end else begin
      duty_d = levdiv4_q;
    end
  end
  assign units_w  = e4_q - 7'(th4_q) * 7'(10);
  assign tenths_w = f4_q - 10'(e4_q) * 10'(10);
  assign hund_w   = d4_q - DigW'(f4_q) * DigW'(10);
  assign rpt_o = '{duty: duty_d, tens: th4_q, units: units_w[3:0],
                   tenths: tenths_w[3:0], hundredths: hund_w[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      gain_q  <= GainReset;
      level_q <= LevelReset;
      duty_q  <= DutyReset;
    end else begin
      if (fifo_pop_o) begin
        s1_v_q <= 1'b1;
      end else if (mv1) begin
        s1_v_q <= 1'b0;
      end
      if (mv1) begin
        s2_v_q <= 1'b1;
      end else if (mv2) begin
        s2_v_q <= 1'b0;
      end
      if (mv2) begin
        s3_v_q <= 1'b1;
      end else if (mv3) begin
        s3_v_q <= 1'b0;
      end
      if (mv3) begin
        s4_v_q <= 1'b1;
      end else if (mv4) begin
        s4_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (mv2) begin
        level_q <= level_d;
      end
      if (mv4) begin
        duty_q <= duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      err1_q  <= err_d;
      tpos1_q <= tpos_d;
    end
    if (mv1) begin
      prod2_q <= err_ext * gain_ext;
      q2_q    <= qprod[31:29];
      tpos2_q <= tpos1_q;
    end
    if (mv2) begin
      lev3_q <= level_d;
      d3_q   <= dfull[DigW-1:0];
    end
    if (mv3) begin
      th4_q     <= th_p[27:24];
      e4_q      <= e_p[25:19];
      f4_q      <= f_p[25:16];
      d4_q      <= d3_q;
      levdiv4_q <= lev_p[26:19];
      levpos4_q <= lev3_q != '0;
      levlow4_q <= lev3_q < LevelStop;
    end
  end

endmodule

// ----- hdl/tfic_report.sv -----
// output buffer: holds one eight-word report and hands it out a word per pop
// depends on tfic_pkg; fed by tfic_ctrl
module tfic_report (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tfic_pkg::report_t rpt_i,
  input  logic              pop_i,
  output logic              empty_o,
  output tfic_pkg::result_t result_o
);
  import tfic_pkg::*;

  logic [7:0]     msg_q [MsgLen];
  logic [7:0]     duty_q;
  logic [IdxW-1:0] idx_q;
  logic           busy_q;
  logic           take, last_word, load;

  assign last_word = idx_q == IdxW'(MsgLen - 1);
  assign take      = pop_i && busy_q;
  assign ready_o   = !busy_q || (take && last_word);
  assign load      = valid_i && ready_o;
  assign empty_o   = !busy_q;
  assign result_o  = '{duty: duty_q, tx_byte: msg_q[idx_q], last: last_word};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (last_word) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + 1'b1;
    end
  end

  // "TT.HH C "
  always_ff @(posedge clk_i) begin
    if (load) begin
      duty_q   <= rpt_i.duty;
      msg_q[0] <= CharZero | 8'(rpt_i.tens);
      msg_q[1] <= CharZero | 8'(rpt_i.units);
      msg_q[2] <= CharDot;
      msg_q[3] <= CharZero | 8'(rpt_i.tenths);
      msg_q[4] <= CharZero | 8'(rpt_i.hundredths);
      msg_q[5] <= CharSpace;
      msg_q[6] <= CharC;
      msg_q[7] <= CharSpace;
    end
  end

endmodule

// ----- hdl/thermistor_fan_integral_controller.sv -----
// Thermistor fan integral controller, top level; built from tfic_front, tfic_fifo, tfic_ctrl
// and tfic_report, all importing tfic_pkg. A set-target word gives no result. An adc sample
// word gives eight result words, the report "TT.HH C " with the fan duty after that sample,
// one word per cycle while pop is held; before the first word appears the sample passes the
// rom read, the queue and the four control stages. Samples are taken every cycle until the
// queue and the pipeline fill; sustained, the sample rate is set by the eight-word report
// buffer. The temperature table is a constant rom, so there is no start-up sweep. The user
// writes the gain register with cfg_we_i only while the block is idle; the block itself does
// not enforce it.
module thermistor_fan_integral_controller #(
  parameter int FIFO_DEPTH = tfic_pkg::FifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tfic_pkg::in_item_t in_item_i,
  output logic               empty,
  input  logic               pop,
  output tfic_pkg::result_t  out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);
  import tfic_pkg::*;

  logic    fe_push, fifo_full, fifo_empty, fifo_pop;
  sample_t fe_data, fifo_data;
  logic    rpt_valid, rpt_ready;
  report_t rpt;

  tfic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fe_push),
    .fifo_data_o (fe_data)
  );

  tfic_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_data),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_data)
  );

  tfic_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_empty_i (fifo_empty),
    .fifo_pop_o   (fifo_pop),
    .fifo_data_i  (fifo_data),
    .rpt_valid_o  (rpt_valid),
    .rpt_ready_i  (rpt_ready),
    .rpt_o        (rpt)
  );

  tfic_report u_report (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rpt_valid),
    .ready_o  (rpt_ready),
    .rpt_i    (rpt),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (out_item_o)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fe_push && fifo_full))
    else $error("front pushed into a full queue");

  a_full_only_with_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> fifo_full)
    else $error("input stalled while the queue had room");

  a_duty_steady_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_item_o.last) |=> (!empty && $stable(out_item_o.duty)))
    else $error("report ended early or duty changed within a report");
`endif

endmodule

// ----- tb/sv/fan_report_checker.sv -----
// Checker for the thermistor fan integral controller: predicts the report words of every
// accepted sample and compares them with the words popped from the block.
// Depends on tfic_pkg for the word types, the command codes and the report characters.
module fan_report_checker
  import tfic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  logic     full_i,
  input  in_item_t item_i,
  input  logic     empty_i,
  input  logic     pop_i,
  input  result_t  word_i,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int       mismatch_count_o,
  output int       words_pending_o,
  output int       words_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CodeTop = 4095;
  localparam int QBits = 28;
  localparam longint unsigned Ln2Fixed = 64'd186065279;
  localparam longint BetaCenti = 64'sd397700;
  localparam longint RoomKelvinCenti = 64'sd29815;
  localparam longint unsigned CurveNum = 64'd11857425500 << QBits;
  localparam int FreezeCenti = 27300;
  localparam int LevelCeiling = 25500;
  localparam int LevelCutoff = 1500;
  localparam logic [7:0] KickDuty = 8'd30;
  localparam logic [7:0] GainAtReset = 8'd32;
  localparam int LevelAtReset = 1000;
  localparam logic [7:0] DutyAtReset = 8'd10;
  localparam logic [7:0] TargetAtReset = 8'd38;
  localparam int ReportShown = 10;

  logic [7:0] gain_q4;
  logic [7:0] target_deg;
  logic [7:0] duty_now;
  int         drive_level;
  result_t    report_queue[$];
  int         mismatches;
  int         checked;

  function automatic longint unsigned log2_fixed(input int unsigned n);
    longint unsigned mant;
    longint unsigned acc;
    int top_bit;
    top_bit = 0;
    for (int b = 0; b < 32; b++) begin
      if ((n >> b) != 0) begin
        top_bit = b;
      end
    end
    mant = (longint'(n) << QBits) >> top_bit;
    acc = longint'(top_bit) << QBits;
    for (int i = QBits - 1; i >= 0; i--) begin
      mant = (mant * mant) >> QBits;
      if (mant >= (64'd2 << QBits)) begin
        mant = mant >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic longint ln_fixed(input int unsigned n);
    return longint'((log2_fixed(n) * Ln2Fixed) >> QBits);
  endfunction

  function automatic int centidegrees_of_code(input logic [11:0] code);
    longint ratio_ln;
    longint denom;
    longint unsigned kelvin;
    if (code == 0 || code >= CodeTop) begin
      return -FreezeCenti;
    end
    ratio_ln = ln_fixed(CodeTop - code) - ln_fixed(int'(code));
    denom = (BetaCenti <<< QBits) + RoomKelvinCenti * ratio_ln;
    if (denom <= 0) begin
      return -FreezeCenti;
    end
    kelvin = (CurveNum + longint'(denom) / 2) / longint'(denom);
    return int'(kelvin) - FreezeCenti;
  endfunction

  task automatic predict_report(input logic [11:0] code);
    int centi;
    longint err;
    longint level_next;
    int shown;
    logic [7:0] msg[8];
    result_t w;
    centi = centidegrees_of_code(code);
    err = longint'(centi) - 100 * longint'(target_deg);
    level_next = longint'(drive_level) + err * longint'(gain_q4) / 16;
    if (level_next > LevelCeiling) begin
      level_next = LevelCeiling;
    end
    if (level_next < 0) begin
      level_next = 0;
    end
    drive_level = int'(level_next);
    if (duty_now == 0) begin
      if (drive_level > 0) begin
        duty_now = KickDuty;
      end
    end else if (drive_level < LevelCutoff) begin
      duty_now = 8'd0;
    end else begin
      duty_now = 8'(drive_level / 100);
    end
    shown = (centi < 0) ? 0 : centi % 10000;
    msg[0] = CharZero + 8'(shown / 1000);
    msg[1] = CharZero + 8'((shown / 100) % 10);
    msg[2] = CharDot;
    msg[3] = CharZero + 8'((shown / 10) % 10);
    msg[4] = CharZero + 8'(shown % 10);
    msg[5] = CharSpace;
    msg[6] = CharC;
    msg[7] = CharSpace;
    for (int k = 0; k < MsgLen; k++) begin
      w.duty = duty_now;
      w.tx_byte = msg[k];
      w.last = (k == MsgLen - 1);
      report_queue.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      gain_q4 = GainAtReset;
      target_deg = TargetAtReset;
      duty_now = DutyAtReset;
      drive_level = LevelAtReset;
      report_queue.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        gain_q4 = cfg_wdata_i;
      end
      if (pop_i && !empty_i) begin
        checked++;
        if (report_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportShown) begin
            $display("word %0d popped with nothing expected: duty %0d byte %h last %b",
                     checked, word_i.duty, word_i.tx_byte, word_i.last);
          end
        end else begin
          want = report_queue.pop_front();
          if (word_i.duty !== want.duty || word_i.tx_byte !== want.tx_byte ||
              word_i.last !== want.last) begin
            mismatches++;
            if (mismatches <= ReportShown) begin
              $display("word %0d mismatch: expected duty %0d byte %h last %b, got %0d %h %b",
                       checked, want.duty, want.tx_byte, want.last,
                       word_i.duty, word_i.tx_byte, word_i.last);
            end
          end
        end
      end
      if (push_i && !full_i) begin
        if (item_i.command == CmdTarget) begin
          target_deg = item_i.target_value;
        end else begin
          predict_report(item_i.adc_code);
        end
      end
    end
    mismatch_count_o <= mismatches;
    words_pending_o <= report_queue.size();
    words_checked_o <= checked;
  end

endmodule

// ----- tb/sv/thermistor_fan_integral_controller_test.sv -----
// Top of the thermistor fan integral controller testbench: clock, reset, stimulus and verdict.
// Depends on tfic_pkg, the block itself and fan_report_checker, which does all the checking.
module thermistor_fan_integral_controller_test;
  import tfic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 24;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    out_item;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  int mismatch_count;
  int words_pending;
  int words_checked;
  int cycle_count = 0;
  int send_gap_max = 8;
  int take_gap_max = 8;
  int items_sent = 0;
  int samples_sent = 0;
  logic [7:0] spare_gain;

  thermistor_fan_integral_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  fan_report_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .item_i          (in_item),
    .empty_i         (empty),
    .pop_i           (pop),
    .word_i          (out_item),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending),
    .words_checked_o (words_checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t sample_word(input logic [11:0] code, input logic [7:0] junk);
    in_item_t it;
    it.command = CmdSample;
    it.adc_code = code;
    it.target_value = junk;
    return it;
  endfunction

  function automatic in_item_t target_word(input logic [7:0] deg, input logic [11:0] junk);
    in_item_t it;
    it.command = CmdTarget;
    it.adc_code = junk;
    it.target_value = deg;
    return it;
  endfunction

  task automatic send_word(input in_item_t it);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (it.command == CmdSample) begin
      samples_sent++;
    end
  endtask

  task automatic drain;
    push <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit pause_midway);
    in_item_t it;
    logic [11:0] code;
    logic [7:0] deg;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      end
      if (pause_midway && i == count / 2) begin
        drain();
      end
      if ($urandom_range(0, 4) == 0) begin
        deg = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(10, 60)) : 8'($urandom);
        it = target_word(deg, 12'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0: code = 12'd0;
          1: code = 12'd4095;
          2: code = 12'($urandom_range(1, 40));
          3: code = 12'($urandom_range(4050, 4094));
          default: code = 12'($urandom);
        endcase
        it = sample_word(code, 8'($urandom));
      end
      send_word(it);
    end
  endtask

  initial begin
    int taken;
    int gap;
    taken = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (taken % 40 == 0) begin
        take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      end
      gap = $urandom_range(0, take_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      taken++;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: singular codes, negative and very hot readings, both duty edges
    send_word(sample_word(12'd2048, 8'h00));
    send_word(sample_word(12'd0, 8'h55));
    send_word(sample_word(12'd4095, 8'hAA));
    send_word(sample_word(12'd4094, 8'h00));
    send_word(sample_word(12'd1, 8'hFF));
    send_word(target_word(8'd255, 12'h000));
    send_word(sample_word(12'd1000, 8'h00));
    send_word(sample_word(12'd1, 8'h00));
    send_word(sample_word(12'd2000, 8'h00));
    send_word(sample_word(12'd500, 8'h00));
    send_word(target_word(8'd0, 12'hFFF));
    send_word(sample_word(12'd4094, 8'h00));
    send_word(sample_word(12'd3500, 8'h00));
    send_word(sample_word(12'd3000, 8'h00));
    send_word(sample_word(12'd4000, 8'h00));
    send_word(target_word(8'd38, 12'hA5A));
    send_word(sample_word(12'd4095, 8'hFF));
    send_word(target_word(8'd25, 12'hFFF));
    send_word(sample_word(12'd2047, 8'h00));
    send_word(sample_word(12'd2049, 8'h00));
    send_word(sample_word(12'd3900, 8'h00));
    send_word(sample_word(12'd100, 8'h00));
    send_word(sample_word(12'd4093, 8'h00));

    write_gain(8'd0);
    run_random(40, 1'b0);
    write_gain(8'd255);
    run_random(50, 1'b1);
    write_gain(8'd1);
    run_random(40, 1'b0);
    spare_gain = 8'($urandom);
    write_gain(spare_gain);
    run_random(60, 1'b0);
    write_gain(8'd16);
    send_gap_max = 0;
    run_random(70, 1'b0);
    drain();

    $display("covered %0d words in (%0d samples), %0d report words checked",
             items_sent, samples_sent, words_checked);
    $display("gains 32, 0, 255, 1, %0d and 16, with random and gap-free idling", spare_gain);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
